/* design/cbpa_pkg.sv */
// Package for the contiguous block pool allocator.
// Holds pool sizing, beat payload types, codes and the index wrap helper.
// No dependencies.
`default_nettype none

package cbpa_pkg;

	localparam int NUM_BLOCKS = 64;
	localparam int IDXW       = $clog2(NUM_BLOCKS);
	localparam int CNTW       = $clog2(NUM_BLOCKS + 1);
	localparam int LENW       = (CNTW > 7) ? CNTW : 7;

	typedef logic [IDXW-1:0] idx_t;
	typedef logic [CNTW-1:0] cnt_t;
	typedef logic [LENW-1:0] len_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;

	localparam cnt_t CNT_ONE  = cnt_t'(1);
	localparam idx_t IDX_LAST = idx_t'(NUM_BLOCKS - 1);

	typedef struct packed {
		logic       operation;
		logic [6:0] block_count;
		logic [5:0] start_block;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] granted_block;
		logic [6:0] blocks_free;
	} rsp_t;

	typedef struct packed {
		logic en;
		idx_t addr;
		cnt_t data;
	} len_wr_t;

	function automatic idx_t wrap_inc(input idx_t i);
		return (i == IDX_LAST) ? '0 : i + idx_t'(1);
	endfunction

endpackage

`default_nettype wire

/* design/cbpa_len_ram.sv */
// Run length memory: one entry per block, length of the run starting there.
// One write port, one registered read port. Depends on cbpa_pkg.
`default_nettype none

module cbpa_len_ram
	import cbpa_pkg::*;
(
	input  wire logic    clk,
	input  wire len_wr_t wr,
	input  wire idx_t    raddr,
	output logic         [CNTW-1:0] rdata
);

	cnt_t mem [NUM_BLOCKS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* design/cbpa_ctrl.sv */
// Sequencer of the allocator: free map, run start flags, rover and free count,
// stepped one block per cycle through a shared index/count unit. Depends on cbpa_pkg.
`default_nettype none

module cbpa_ctrl
	import cbpa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire req_t  request,
	output logic       busy,
	output logic       done,
	output rsp_t       result,
	output len_wr_t    len_wr,
	output idx_t       len_raddr,
	input  wire cnt_t  len_rdata
);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_SCAN      = 3'd1;
	localparam logic [2:0] S_MARK      = 3'd2;
	localparam logic [2:0] S_ROVER     = 3'd3;
	localparam logic [2:0] S_FREE_RD   = 3'd4;
	localparam logic [2:0] S_FREE_LOOP = 3'd5;
	localparam logic [2:0] S_REPLY     = 3'd6;

	logic [2:0]            state_q, state_d;
	logic [NUM_BLOCKS-1:0] free_map_q, free_map_d;
	logic [NUM_BLOCKS-1:0] start_q, start_d;
	idx_t                  rover_q, rover_d;
	cnt_t                  free_total_q, free_total_d;

	idx_t       idx_q, idx_d;
	idx_t       first_q, first_d;
	cnt_t       k_q, k_d;
	cnt_t       len_q, len_d;
	cnt_t       cnt_q, cnt_d;
	logic [1:0] status_q, status_d;
	logic [5:0] granted_q, granted_d;

	cnt_t lenb;
	cnt_t lenn;
	len_t cnt_in;
	len_t s_in;
	idx_t s_idx;

	always_comb begin
		state_d      = state_q;
		free_map_d   = free_map_q;
		start_d      = start_q;
		rover_d      = rover_q;
		free_total_d = free_total_q;
		idx_d        = idx_q;
		first_d      = first_q;
		k_d          = k_q;
		len_d        = len_q;
		cnt_d        = cnt_q;
		status_d     = status_q;
		granted_d    = granted_q;
		len_wr       = '0;
		done         = 1'b0;

		cnt_in    = len_t'(request.block_count);
		s_in      = len_t'(request.start_block);
		s_idx     = idx_t'(request.start_block);
		len_raddr = s_idx;
		lenb      = (idx_q == '0) ? '0 : len_q;
		lenn      = lenb + CNT_ONE;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cnt_d     = cnt_t'(request.block_count);
					granted_d = '0;
					status_d  = ST_OK;
					k_d       = '0;
					if (request.operation == OP_ALLOC) begin
						if (cnt_in == '0 || cnt_in > len_t'(free_total_q)) begin
							status_d = ST_NOFIT;
							state_d  = S_REPLY;
						end else begin
							idx_d   = rover_q;
							len_d   = '0;
							state_d = S_SCAN;
						end
					end else begin
						priority if (s_in >= len_t'(NUM_BLOCKS)) begin
							status_d = ST_BADFREE;
							state_d  = S_REPLY;
						end else if (free_map_q[s_idx] || !start_q[s_idx]) begin
							status_d = ST_BADFREE;
							state_d  = S_REPLY;
						end else begin
							idx_d   = s_idx;
							state_d = S_FREE_RD;
						end
					end
				end
			end
			S_SCAN: begin
				idx_d = wrap_inc(idx_q);
				k_d   = k_q + CNT_ONE;
				if (free_map_q[idx_q]) begin
					len_d = lenn;
					if (lenb == '0) begin
						first_d = idx_q;
					end
				end else begin
					len_d = '0;
				end
				if (free_map_q[idx_q] && lenn == cnt_q) begin
					idx_d   = (lenb == '0) ? idx_q : first_q;
					k_d     = '0;
					state_d = S_MARK;
				end else if (k_q == cnt_t'(NUM_BLOCKS - 1)) begin
					status_d = ST_NOFIT;
					state_d  = S_REPLY;
				end
			end
			S_MARK: begin
				free_map_d[idx_q] = 1'b0;
				free_total_d      = free_total_q - CNT_ONE;
				k_d               = k_q + CNT_ONE;
				idx_d             = wrap_inc(idx_q);
				if (k_q + CNT_ONE == cnt_q) begin
					len_wr.en        = 1'b1;
					len_wr.addr      = first_q;
					len_wr.data      = cnt_q;
					start_d[first_q] = 1'b1;
					granted_d        = 6'(first_q);
					if (free_total_q == CNT_ONE) begin
						rover_d = '0;
						state_d = S_REPLY;
					end else begin
						state_d = S_ROVER;
					end
				end
			end
			S_ROVER: begin
				if (free_map_q[idx_q]) begin
					rover_d = idx_q;
					state_d = S_REPLY;
				end else begin
					idx_d = wrap_inc(idx_q);
				end
			end
			S_FREE_RD: begin
				len_d          = len_rdata;
				start_d[idx_q] = 1'b0;
				if (free_total_q == '0 || idx_q < rover_q) begin
					rover_d = idx_q;
				end
				state_d = S_FREE_LOOP;
			end
			S_FREE_LOOP: begin
				free_map_d[idx_q] = 1'b1;
				free_total_d      = free_total_q + CNT_ONE;
				k_d               = k_q + CNT_ONE;
				idx_d             = wrap_inc(idx_q);
				if (k_q + CNT_ONE == len_q || idx_q == IDX_LAST) begin
					state_d = S_REPLY;
				end
			end
			S_REPLY: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy                 = (state_q != S_IDLE);
	assign result.status        = status_q;
	assign result.granted_block = granted_q;
	assign result.blocks_free   = 7'(free_total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_map_q   <= '1;
			start_q      <= '0;
			rover_q      <= '0;
			free_total_q <= cnt_t'(NUM_BLOCKS);
		end else begin
			state_q      <= state_d;
			free_map_q   <= free_map_d;
			start_q      <= start_d;
			rover_q      <= rover_d;
			free_total_q <= free_total_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		first_q   <= first_d;
		k_q       <= k_d;
		len_q     <= len_d;
		cnt_q     <= cnt_d;
		status_q  <= status_d;
		granted_q <= granted_d;
	end

endmodule

`default_nettype wire

/* design/contiguous_block_pool_allocator.sv */
// Top level of the contiguous block pool allocator: sequencer, run length memory
// and result register. Depends on cbpa_pkg, cbpa_ctrl, cbpa_len_ram.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------
//   command  | start, busy        | request (req_t)
//   result   | done (one cycle)   | result  (rsp_t)
//
// Steps from accept to result: an allocation scans from the rover, at most the
// whole pool, then marks the found run, then steps the rover on to a free block
// (not when the pool runs out); one block per cycle. A free reads the run length,
// then frees the run. A command refused at accept goes straight to the result; an
// allocation with no fitting run scans the whole pool first.
// Reset sets all blocks free at once; a command is taken on the first idle cycle.
// Results are not stalled; busy drops in the result cycle, so the next command
// can be taken at the edge that takes the result.
`default_nettype none

module contiguous_block_pool_allocator
	import cbpa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t request,
	output logic      busy,
	output logic      done,
	output rsp_t      result
);

	len_wr_t len_wr;
	idx_t    len_raddr;
	cnt_t    len_rdata;
	logic    ctrl_done;
	rsp_t    ctrl_result;

	cbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.done      (ctrl_done),
		.result    (ctrl_result),
		.len_wr    (len_wr),
		.len_raddr (len_raddr),
		.len_rdata (len_rdata)
	);

	cbpa_len_ram u_len_ram (
		.clk   (clk),
		.wr    (len_wr),
		.raddr (len_raddr),
		.rdata (len_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctrl_done;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_done) begin
			result <= ctrl_result;
		end
	end

endmodule

`default_nettype wire

/* design/cbpa_checker.sv */
// Port level checks for the contiguous block pool allocator, bound to the top.
// Depends on cbpa_pkg and contiguous_block_pool_allocator.
`default_nettype none

module cbpa_port_checks
	import cbpa_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire rsp_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beats back to back");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_NOFIT ||
			result.status == ST_BADFREE))
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.granted_block == '0)
		else $error("failed request carries a granted block");

endmodule

bind contiguous_block_pool_allocator cbpa_port_checks u_cbpa_port_checks (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.result  (result)
);

`default_nettype wire

/* sim/cbpa_checker.sv */
// Result checker for the contiguous block pool allocator: tracks the pool in its own
// model, predicts one result beat per command beat and compares every field.
// Depends on cbpa_pkg.
module cbpa_checker
	import cbpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t request,
	input  logic done,
	input  rsp_t result,
	output int   fails,
	output int   pending,
	output int   n_granted,
	output int   n_refused,
	output int   n_returned,
	output int   n_rejected
);
	timeunit 1ns;
	timeprecision 1ps;

	bit   blk_free [NUM_BLOCKS];
	int   run_len [NUM_BLOCKS];
	int   rover;
	int   avail;
	int   n_results;
	rsp_t expected_results[$];

	task automatic flag_mismatch(input string what, input logic [7:0] want,
			input logic [7:0] got);
		$display("%0t: result %0d, %s: expected %0d, got %0d", $time, n_results, what,
			want, got);
		fails++;
	endtask

	// advance the pool model by one command and return the result it causes
	function automatic rsp_t pool_step(input req_t r);
		rsp_t o;
		int   cnt;
		int   len;
		int   first;
		int   idx;
		int   k;
		bit   found;
		o = '0;
		if (r.operation == OP_ALLOC) begin
			cnt = int'(r.block_count);
			found = 1'b0;
			len = 0;
			first = 0;
			if (cnt != 0 && cnt <= avail) begin
				for (k = 0; k < NUM_BLOCKS && !found; k++) begin
					idx = (rover + k) % NUM_BLOCKS;
					if (idx == 0)
						len = 0;
					if (blk_free[idx]) begin
						len++;
						if (len == 1)
							first = idx;
						if (len == cnt)
							found = 1'b1;
					end else begin
						len = 0;
					end
				end
			end
			if (!found) begin
				o.status = ST_NOFIT;
			end else begin
				for (k = 0; k < cnt; k++)
					blk_free[first + k] = 1'b0;
				run_len[first] = cnt;
				avail -= cnt;
				rover = 0;
				found = 1'b0;
				for (k = 0; k < NUM_BLOCKS && !found; k++) begin
					idx = (first + cnt + k) % NUM_BLOCKS;
					if (blk_free[idx]) begin
						rover = idx;
						found = 1'b1;
					end
				end
				o.status = ST_OK;
				o.granted_block = 6'(first);
			end
		end else begin
			idx = int'(r.start_block);
			if (idx >= NUM_BLOCKS || blk_free[idx] || run_len[idx] == 0) begin
				o.status = ST_BADFREE;
			end else begin
				for (k = 0; k < run_len[idx] && idx + k < NUM_BLOCKS; k++)
					blk_free[idx + k] = 1'b1;
				run_len[idx] = 0;
				if (avail == 0 || idx < rover)
					rover = idx;
				avail += k;
				o.status = ST_OK;
			end
		end
		o.blocks_free = 7'(avail);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				blk_free[i] = 1'b1;
				run_len[i] = 0;
			end
			rover = 0;
			avail = NUM_BLOCKS;
			expected_results.delete();
			fails = 0;
			n_results = 0;
			n_granted = 0;
			n_refused = 0;
			n_returned = 0;
			n_rejected = 0;
			pending <= 0;
		end else begin
			if (done) begin
				n_results++;
				if (expected_results.size() == 0) begin
					flag_mismatch("beat with nothing outstanding, status", 8'd0,
						8'(result.status));
				end else begin
					want = expected_results.pop_front();
					if (result.status !== want.status)
						flag_mismatch("status", 8'(want.status), 8'(result.status));
					if (result.granted_block !== want.granted_block)
						flag_mismatch("granted_block", 8'(want.granted_block),
							8'(result.granted_block));
					if (result.blocks_free !== want.blocks_free)
						flag_mismatch("blocks_free", 8'(want.blocks_free),
							8'(result.blocks_free));
				end
			end
			if (start && !busy) begin
				want = pool_step(request);
				expected_results.push_back(want);
				if (want.status == ST_NOFIT)
					n_refused++;
				else if (want.status == ST_BADFREE)
					n_rejected++;
				else if (request.operation == OP_ALLOC)
					n_granted++;
				else
					n_returned++;
			end
			pending <= expected_results.size();
		end
	end

endmodule

/* sim/testbench.sv */
// Top of the allocator testbench: clock, reset, command stimulus and verdict.
// Depends on cbpa_pkg, contiguous_block_pool_allocator and cbpa_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cbpa_pkg::*;

	localparam int N_RANDOM     = 1700;
	localparam int N_DIRECTED   = 22;
	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int DRAIN_CYCLES = 3 * NUM_BLOCKS + 80;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t request;
	rsp_t result;

	int   fails;
	int   pending;
	int   n_granted;
	int   n_refused;
	int   n_returned;
	int   n_rejected;
	int   cycles = 0;
	int   live_runs[$];
	req_t sent_reqs[$];

	contiguous_block_pool_allocator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	cbpa_checker pool_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.fails      (fails),
		.pending    (pending),
		.n_granted  (n_granted),
		.n_refused  (n_refused),
		.n_returned (n_returned),
		.n_rejected (n_rejected)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("no verdict after %0d cycles, %0d results outstanding", cycles, pending);
			$display("simulation failed");
			$finish;
		end
	end

	// keep the starts of granted runs so that most frees hit a live run
	always @(posedge clk) begin
		req_t r;
		if (arst_n) begin
			if (done && sent_reqs.size() != 0) begin
				r = sent_reqs.pop_front();
				if (result.status == ST_OK) begin
					if (r.operation == OP_ALLOC) begin
						live_runs.push_back(int'(result.granted_block));
					end else begin
						for (int i = 0; i < live_runs.size(); i++) begin
							if (live_runs[i] == int'(r.start_block)) begin
								live_runs.delete(i);
								break;
							end
						end
					end
				end
			end
			if (start && !busy)
				sent_reqs.push_back(request);
		end
	end

	function automatic req_t make_cmd(input logic op, input int cnt, input int blk);
		req_t r;
		r.operation = op;
		r.block_count = 7'(cnt);
		r.start_block = 6'(blk);
		return r;
	endfunction

	// hold start until the beat is taken; optionally drop start for a while first
	task automatic send_cmd(input req_t r, input bit may_idle);
		if (may_idle && $urandom_range(99) < 30) begin
			start <= 1'b0;
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(150, 1)) @(posedge clk);
			else
				repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		logic dir_op [N_DIRECTED];
		int   dir_arg [N_DIRECTED];
		req_t r;
		int   cnt;
		int   blk;
		int   pick;
		dir_op = '{OP_ALLOC, OP_ALLOC, OP_ALLOC, OP_FREE, OP_ALLOC, OP_ALLOC, OP_FREE,
			OP_FREE, OP_ALLOC, OP_ALLOC, OP_FREE, OP_ALLOC, OP_ALLOC, OP_ALLOC, OP_ALLOC,
			OP_ALLOC, OP_FREE, OP_FREE, OP_FREE, OP_FREE, OP_FREE, OP_FREE};
		dir_arg = '{0, 127, 65, 0, 64, 1, 63, 0, 4, 52, 0, 5, 5, 8, 4, 3, 4, 5, 4, 56, 0, 61};
		arst_n <= 1'b0;
		start <= 1'b0;
		request <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (dir_op[i] == OP_ALLOC)
				r = make_cmd(OP_ALLOC, dir_arg[i], $urandom_range(63));
			else
				r = make_cmd(OP_FREE, $urandom_range(127), dir_arg[i]);
			send_cmd(r, 1'b1);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (live_runs.size() != 0 && $urandom_range(99) < 45) begin
				if ($urandom_range(9) == 0)
					blk = $urandom_range(63);
				else
					blk = live_runs[$urandom_range(live_runs.size() - 1)];
				r = make_cmd(OP_FREE, $urandom_range(127), blk);
			end else begin
				pick = $urandom_range(99);
				if (pick < 65)
					cnt = $urandom_range(6, 1);
				else if (pick < 88)
					cnt = $urandom_range(64, 7);
				else if (pick < 94)
					cnt = 0;
				else
					cnt = $urandom_range(127, 65);
				r = make_cmd(OP_ALLOC, cnt, $urandom_range(63));
			end
			send_cmd(r, !(i >= 600 && i < 950));
		end
		start <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d granted runs and %0d refused allocations", n_granted, n_refused);
		$display("returned %0d runs, turned away %0d frees of unallocated blocks",
			n_returned, n_rejected);
		if (fails == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
design/cbpa_pkg.sv
design/cbpa_len_ram.sv
design/cbpa_ctrl.sv
design/contiguous_block_pool_allocator.sv
design/cbpa_checker.sv
sim/cbpa_checker.sv
sim/testbench.sv
